// ===== hw/rtl/rrt_pkg.sv =====
// Shared types and constants of the received range tracker.
// Used by rrt_cell, rrt_report and received_range_tracker_unit.
package rrt_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // input kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_ADOPT  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED    = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_CAPACITY    = 3'd2;
  localparam logic [2:0] ST_ADOPTED     = 3'd3;
  localparam logic [2:0] ST_NOT_ADOPTED = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_TRUSTED_VALID = 2'd0;
  localparam logic [1:0] REG_TRUSTED_LEN   = 2'd1;
  localparam logic [1:0] REG_SLACK         = 2'd2;
  localparam logic [1:0] REG_MAX_REQ       = 2'd3;

  // cell operations
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_WIDEN  = 3'd2;
  localparam logic [2:0] CELL_MERGE  = 3'd3;
  localparam logic [2:0] CELL_ROTATE = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] offset;
    logic [7:0]  count;
    logic        infer_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_offset;
    logic [31:0] next_length;
    logic        length_known;
    logic [31:0] total_bytes;
    logic        done_res;
  } out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] off;
    logic [31:0] endv;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/rrt_cell.sv =====
// One cell of the range chain: holds one [start, end) range.
// Depends on rrt_pkg.
module rrt_cell (
  input  logic               clk,
  input  rrt_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  logic               prev_below,
  input  logic [31:0]        lft_s,
  input  logic [31:0]        lft_e,
  input  logic [31:0]        rgt_s,
  input  logic [31:0]        rgt_e,
  input  logic               rgt_valid,
  output logic [31:0]        s_o,
  output logic [31:0]        e_o,
  output logic               below,
  output logic               touch,
  output logic               pair
);

  logic [31:0] s_r, e_r, s_nxt, e_nxt;
  logic        at_first, after;

  assign below    = valid && (e_r < ctrl.off);
  assign touch    = valid && (e_r >= ctrl.off) && (s_r <= ctrl.endv);
  // below flags form a prefix, so at most one cell sits at the packet position
  assign at_first = prev_below && !below;
  assign after    = !prev_below;
  assign pair     = at_first && valid && rgt_valid && (rgt_s <= e_r);

  always_comb begin
    s_nxt = s_r;
    e_nxt = e_r;
    case (ctrl.op)
      rrt_pkg::CELL_INSERT: begin
        if (at_first) begin
          s_nxt = ctrl.off;
          e_nxt = ctrl.endv;
        end else if (after) begin
          s_nxt = lft_s;
          e_nxt = lft_e;
        end
      end
      rrt_pkg::CELL_WIDEN: begin
        if (at_first) begin
          s_nxt = (s_r < ctrl.off) ? s_r : ctrl.off;
          e_nxt = (e_r > ctrl.endv) ? e_r : ctrl.endv;
        end
      end
      rrt_pkg::CELL_MERGE: begin
        if (at_first) begin
          e_nxt = (rgt_e > e_r) ? rgt_e : e_r;
        end else if (after) begin
          s_nxt = rgt_s;
          e_nxt = rgt_e;
        end
      end
      rrt_pkg::CELL_ROTATE: begin
        s_nxt = rgt_s;
        e_nxt = rgt_e;
      end
      default: begin
        s_nxt = s_r;
        e_nxt = e_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    e_r <= e_nxt;
  end

  assign s_o = s_r;
  assign e_o = e_r;

endmodule

// ===== hw/rtl/rrt_report.sv =====
// Report accumulator: walks the ranges as they rotate past the chain head.
// Depends on rrt_pkg.
module rrt_report (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        step,
  input  logic        ent_valid,
  input  logic [31:0] ent_s,
  input  logic [31:0] ent_e,
  input  logic        tv,
  input  logic [31:0] tl,
  input  logic [31:0] max_req,
  output logic [31:0] next_offset,
  output logic [31:0] next_length,
  output logic        done
);

  logic [31:0] cursor_r, cursor_nxt, missing_r, missing_nxt, covered_r, covered_nxt;
  logic        stop1_r, stop1_nxt, stop2_r, stop2_nxt, miss_r, miss_nxt;
  logic [31:0] limit, c2, e_clip, missing, rem;

  assign limit = tv ? tl : rrt_pkg::ALL_ONES;

  always_comb begin
    cursor_nxt  = cursor_r;
    missing_nxt = missing_r;
    covered_nxt = covered_r;
    stop1_nxt   = stop1_r;
    stop2_nxt   = stop2_r;
    miss_nxt    = miss_r;
    c2          = (ent_e > cursor_r) ? ent_e : cursor_r;
    e_clip      = (tv && ent_e > limit) ? limit : ent_e;
    if (clr) begin
      cursor_nxt  = '0;
      covered_nxt = '0;
      stop1_nxt   = 1'b0;
      stop2_nxt   = 1'b0;
      miss_nxt    = 1'b0;
    end else if (step && ent_valid) begin
      if (!stop1_r) begin
        if (ent_s > cursor_r) begin
          miss_nxt    = 1'b1;
          missing_nxt = (ent_s < limit) ? ent_s : limit;
          stop1_nxt   = 1'b1;
        end else if (c2 >= limit) begin
          cursor_nxt = limit;
          stop1_nxt  = 1'b1;
        end else begin
          cursor_nxt = c2;
        end
      end
      if (!stop2_r) begin
        if (tv && ent_s >= limit) begin
          stop2_nxt = 1'b1;
        end else begin
          covered_nxt = covered_r + (e_clip - ent_s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop1_r <= 1'b0;
      stop2_r <= 1'b0;
      miss_r  <= 1'b0;
    end else begin
      stop1_r <= stop1_nxt;
      stop2_r <= stop2_nxt;
      miss_r  <= miss_nxt;
    end
    cursor_r  <= cursor_nxt;
    missing_r <= missing_nxt;
    covered_r <= covered_nxt;
  end

  // no gap found: the missing run reaches the limit
  assign missing     = miss_r ? missing_r : limit;
  assign rem         = (missing > cursor_r) ? (missing - cursor_r) : '0;
  assign next_offset = cursor_r;
  assign next_length = !tv ? rrt_pkg::ALL_ONES : ((rem < max_req) ? rem : max_req);
  assign done        = tv && (covered_r >= tl);

endmodule

// ===== hw/rtl/received_range_tracker_unit.sv =====
// Top level of the received range tracker: control sequencer, range cell chain
// and report unit. Depends on rrt_pkg, rrt_cell and rrt_report.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | in_valid / in_ready    | in_data  (rrt_pkg::in_t)
//  out      | out_valid / out_ready  | out_data (rrt_pkg::out_t)
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// An item passes from acceptance through evaluation, one merge step per stored
// range it absorbs, and the report rotation of the cell chain (one range per cycle)
// to the result. One item is in flight at a time; the next request is taken only
// once the result is loaded into the out register.
// Reset clears the range count and all length state; cell contents need none.
// A result waiting on out_ready holds the last step until the out register frees.
module received_range_tracker_unit #(
  parameter int MAX_RANGES  = 16,
  parameter int PACKET_SIZE = 90
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrt_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrt_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_REPORT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  rrt_pkg::in_t     item_r;
  logic [2:0]       status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, ridx_r, ridx_nxt;
  logic [31:0]      hi_r, hi_nxt, pl_r, pl_nxt, tl_r, tl_nxt;
  logic             pv_r, pv_nxt, tv_r, tv_nxt;
  logic [31:0]      slack_r, max_req_r;
  rrt_pkg::out_t    out_r;
  logic             out_valid_r;

  rrt_pkg::cell_ctrl_t ctrl;
  logic [31:0] s_w [MAX_RANGES];
  logic [31:0] e_w [MAX_RANGES];
  logic [MAX_RANGES-1:0] below_w, touch_w, pair_w, valid_w;
  logic any_touch, go;

  logic [32:0] end33;
  logic [31:0] end32, frontier;
  logic        bad, near, cap_fail, short_ok;
  logic        rpt_clr, rpt_step;
  logic [31:0] rpt_off, rpt_len;
  logic        rpt_done;

  // ---------------- cell chain ----------------
  genvar j;
  generate
    for (j = 0; j < MAX_RANGES; j++) begin : g_cell
      logic        pb, rv;
      logic [31:0] ls, le, rs, re;
      if (j == 0) begin : g_head
        assign pb = 1'b1;
        assign ls = s_w[0];
        assign le = e_w[0];
      end else begin : g_body
        assign pb = below_w[j-1];
        assign ls = s_w[j-1];
        assign le = e_w[j-1];
      end
      if (j == MAX_RANGES - 1) begin : g_tail
        // tail wraps to the head for the report rotation
        assign rs = s_w[0];
        assign re = e_w[0];
        assign rv = 1'b0;
      end else begin : g_mid
        assign rs = s_w[j+1];
        assign re = e_w[j+1];
        assign rv = valid_w[j+1];
      end
      assign valid_w[j] = (CNT_W'(j) < count_r);
      rrt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (valid_w[j]),
        .prev_below(pb),
        .lft_s     (ls),
        .lft_e     (le),
        .rgt_s     (rs),
        .rgt_e     (re),
        .rgt_valid (rv),
        .s_o       (s_w[j]),
        .e_o       (e_w[j]),
        .below     (below_w[j]),
        .touch     (touch_w[j]),
        .pair      (pair_w[j])
      );
    end
  endgenerate

  assign any_touch = |touch_w;
  assign go        = |pair_w;

  rrt_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (rpt_clr),
    .step       (rpt_step),
    .ent_valid  (ridx_r < count_r),
    .ent_s      (s_w[0]),
    .ent_e      (e_w[0]),
    .tv         (tv_r),
    .tl         (tl_r),
    .max_req    (max_req_r),
    .next_offset(rpt_off),
    .next_length(rpt_len),
    .done       (rpt_done)
  );

  // ---------------- packet evaluation ----------------
  assign end33    = {1'b0, item_r.offset} + {25'd0, item_r.count};
  assign end32    = end33[31:0];
  assign bad      = (item_r.count > 8'(PACKET_SIZE)) || end33[32];
  assign frontier = (count_r != '0 && s_w[0] == '0) ? e_w[0] : '0;
  assign near     = {1'b0, item_r.offset} <= ({1'b0, frontier} + {1'b0, slack_r});
  assign cap_fail = (item_r.count != '0) && !any_touch && (count_r == CNT_W'(MAX_RANGES));
  assign short_ok = item_r.infer_length && (item_r.count < 8'(PACKET_SIZE)) && (end32 >= hi_r);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    ridx_nxt   = ridx_r;
    hi_nxt     = hi_r;
    pv_nxt     = pv_r;
    pl_nxt     = pl_r;
    tv_nxt     = tv_r;
    tl_nxt     = tl_r;
    rpt_clr    = 1'b0;
    rpt_step   = 1'b0;
    ctrl.op    = rrt_pkg::CELL_HOLD;
    ctrl.off   = item_r.offset;
    ctrl.endv  = end32;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_REPORT;
        rpt_clr   = 1'b1;
        ridx_nxt  = '0;
        if (item_r.kind == rrt_pkg::KIND_ADOPT) begin
          if (tv_r || !pv_r) begin
            status_nxt = rrt_pkg::ST_NOT_ADOPTED;
          end else begin
            status_nxt = rrt_pkg::ST_ADOPTED;
            tv_nxt     = 1'b1;
            tl_nxt     = pl_r;
            pv_nxt     = 1'b0;
            pl_nxt     = '0;
          end
        end else if (bad) begin
          status_nxt = rrt_pkg::ST_INVALID;
        end else if (cap_fail) begin
          status_nxt = rrt_pkg::ST_CAPACITY;
        end else begin
          status_nxt = rrt_pkg::ST_ACCEPTED;
          if (short_ok) begin
            if (near) begin
              tv_nxt = 1'b1;
              tl_nxt = end32;
            end else if (!pv_r || end32 > pl_r) begin
              pv_nxt = 1'b1;
              pl_nxt = end32;
            end
          end else begin
            pv_nxt = 1'b0;
            pl_nxt = '0;
          end
          if (near && end32 > hi_r) begin
            hi_nxt = end32;
          end
          if (item_r.count != '0) begin
            if (any_touch) begin
              ctrl.op   = rrt_pkg::CELL_WIDEN;
              state_nxt = S_MERGE;
              rpt_clr   = 1'b0;
            end else begin
              ctrl.op   = rrt_pkg::CELL_INSERT;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end
      S_MERGE: begin
        // absorb one neighbor of the widened range per cycle
        if (go) begin
          ctrl.op   = rrt_pkg::CELL_MERGE;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = S_REPORT;
          rpt_clr   = 1'b1;
          ridx_nxt  = '0;
        end
      end
      S_REPORT: begin
        ctrl.op  = rrt_pkg::CELL_ROTATE;
        rpt_step = 1'b1;
        ridx_nxt = ridx_r + CNT_W'(1);
        if (ridx_r == CNT_W'(MAX_RANGES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ridx_r      <= '0;
      hi_r        <= '0;
      pv_r        <= 1'b0;
      pl_r        <= '0;
      tv_r        <= 1'b0;
      tl_r        <= '0;
      slack_r     <= '0;
      max_req_r   <= rrt_pkg::ALL_ONES;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ridx_r  <= ridx_nxt;
      hi_r    <= hi_nxt;
      pv_r    <= pv_nxt;
      pl_r    <= pl_nxt;
      tv_r    <= tv_nxt;
      tl_r    <= tl_nxt;
      // trusted length writes are ignored; it comes from reset, adoption or length inference
      if (cfg_we) begin
        case (cfg_index)
          rrt_pkg::REG_SLACK:   slack_r   <= cfg_data;
          rrt_pkg::REG_MAX_REQ: max_req_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    status_r <= status_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.status       <= status_r;
      out_r.next_offset  <= rpt_off;
      out_r.next_length  <= rpt_len;
      out_r.length_known <= tv_r;
      out_r.total_bytes  <= tv_r ? tl_r : '0;
      out_r.done_res     <= rpt_done;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("range count above capacity");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the final step");

  a_report_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REPORT |=> $stable(count_r))
    else $error("range count moved during report rotation");

  a_merge_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE && go) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("merge step did not drop one range");
`endif

endmodule

// ===== tb/rrt_checker.sv =====
// Scoreboard of the received range tracker: watches the request and result channels
// and the config port, keeps its own range list, and compares every result.
// Depends on rrt_pkg.
module rrt_checker #(
  parameter int MAX_RANGES  = 16,
  parameter int PACKET_SIZE = 90
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rrt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rrt_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            mismatches,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TOP = 64'hFFFF_FFFF;

  logic [31:0] slack_q, max_req_q;
  logic [31:0] rng_lo [MAX_RANGES];
  logic [31:0] rng_hi [MAX_RANGES];
  int          n_ranges;
  logic [31:0] top_end;
  logic        pend_v, tot_v;
  logic [31:0] pend_len, tot_len;

  rrt_pkg::out_t expected_results[$];

  function automatic rrt_pkg::out_t summarize(logic [2:0] st);
    rrt_pkg::out_t r;
    logic [63:0] limit, cursor, missing, covered, e, rem;
    int i;
    limit = tot_v ? {32'd0, tot_len} : TOP;
    cursor = 0;
    missing = limit;
    covered = 0;
    for (i = 0; i < n_ranges; i++) begin
      if (rng_lo[i] > cursor) begin
        missing = (rng_lo[i] < limit) ? rng_lo[i] : limit;
        break;
      end
      if (rng_hi[i] > cursor) cursor = rng_hi[i];
      if (cursor >= limit) begin
        cursor = limit;
        break;
      end
    end
    r.status = st;
    r.next_offset = cursor[31:0];
    if (!tot_v) begin
      r.next_length = rrt_pkg::ALL_ONES;
    end else begin
      rem = (missing > cursor) ? missing - cursor : 0;
      r.next_length = (rem < max_req_q) ? rem[31:0] : max_req_q;
    end
    for (i = 0; i < n_ranges; i++) begin
      if (tot_v && rng_lo[i] >= limit) break;
      e = rng_hi[i];
      if (tot_v && e > limit) e = limit;
      covered += e - rng_lo[i];
    end
    r.length_known = tot_v;
    r.total_bytes = tot_v ? tot_len : 32'd0;
    r.done_res = tot_v && (covered >= tot_len);
    return r;
  endfunction

  function automatic rrt_pkg::out_t track_request(rrt_pkg::in_t it);
    logic [63:0] off, endv, front;
    int first, last, i, n;
    logic near;
    logic [31:0] s, e;
    if (it.kind == rrt_pkg::KIND_ADOPT) begin
      if (tot_v || !pend_v) return summarize(rrt_pkg::ST_NOT_ADOPTED);
      tot_v = 1;
      tot_len = pend_len;
      pend_v = 0;
      pend_len = 0;
      return summarize(rrt_pkg::ST_ADOPTED);
    end
    off = {32'd0, it.offset};
    endv = off + it.count;
    if (it.count > PACKET_SIZE || endv > TOP) return summarize(rrt_pkg::ST_INVALID);
    first = 0;
    last = 0;
    if (it.count != 0) begin
      while (first < n_ranges && rng_hi[first] < off) first++;
      last = first;
      while (last < n_ranges && rng_lo[last] <= endv) last++;
      if (n_ranges - (last - first) + 1 > MAX_RANGES)
        return summarize(rrt_pkg::ST_CAPACITY);
    end
    front = (n_ranges == 0 || rng_lo[0] != 0) ? 64'd0 : {32'd0, rng_hi[0]};
    near = off <= front + slack_q;
    if (it.infer_length && it.count < PACKET_SIZE && endv >= top_end) begin
      if (near) begin
        tot_v = 1;
        tot_len = endv[31:0];
      end else if (!pend_v || endv > pend_len) begin
        pend_v = 1;
        pend_len = endv[31:0];
      end
    end else begin
      pend_v = 0;
      pend_len = 0;
    end
    if (near && endv > top_end) top_end = endv[31:0];
    if (it.count != 0) begin
      s = off[31:0];
      e = endv[31:0];
      for (i = first; i < last; i++) begin
        if (rng_lo[i] < s) s = rng_lo[i];
        if (rng_hi[i] > e) e = rng_hi[i];
      end
      n = n_ranges - last;
      // an insert opens a slot, so the tail moves up from its far end
      if (last == first) begin
        for (i = n - 1; i >= 0; i--) begin
          rng_lo[first + 1 + i] = rng_lo[last + i];
          rng_hi[first + 1 + i] = rng_hi[last + i];
        end
      end else begin
        for (i = 0; i < n; i++) begin
          rng_lo[first + 1 + i] = rng_lo[last + i];
          rng_hi[first + 1 + i] = rng_hi[last + i];
        end
      end
      rng_lo[first] = s;
      rng_hi[first] = e;
      n_ranges = n_ranges - (last - first) + 1;
    end
    return summarize(rrt_pkg::ST_ACCEPTED);
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    rrt_pkg::out_t want;
    if (!rst_n) begin
      slack_q = 0;
      max_req_q = rrt_pkg::ALL_ONES;
      n_ranges = 0;
      top_end = 0;
      pend_v = 0;
      pend_len = 0;
      tot_v = 0;
      tot_len = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rrt_pkg::REG_SLACK:   slack_q = cfg_data;
          rrt_pkg::REG_MAX_REQ: max_req_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(track_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_data.status || want.next_offset !== out_data.next_offset ||
              want.next_length !== out_data.next_length ||
              want.length_known !== out_data.length_known ||
              want.total_bytes !== out_data.total_bytes ||
              want.done_res !== out_data.done_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected st=%0d off=%h len=%h known=%b tot=%h done=%b",
                       want.status, want.next_offset, want.next_length, want.length_known,
                       want.total_bytes, want.done_res);
              $display("          got      st=%0d off=%h len=%h known=%b tot=%h done=%b",
                       out_data.status, out_data.next_offset, out_data.next_length,
                       out_data.length_known, out_data.total_bytes, out_data.done_res);
            end
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_received_range_tracker_unit.sv =====
// Testbench top of the received range tracker: clock, reset, request and config
// stimulus, result-side backpressure and the verdict. Depends on rrt_pkg and rrt_checker.
module tb_received_range_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RANGES  = 16;
  localparam int PACKET_SIZE = 90;
  localparam int LIMIT = 600000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  rrt_pkg::in_t  in_data;
  rrt_pkg::out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int mismatches, outstanding, cycles;
  logic no_idle;
  int span;

  received_range_tracker_unit #(.MAX_RANGES(MAX_RANGES), .PACKET_SIZE(PACKET_SIZE)) uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  rrt_checker #(.MAX_RANGES(MAX_RANGES), .PACKET_SIZE(PACKET_SIZE)) chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_received_range_tracker_unit: FAIL");
        $finish;
      end
    end
  end

  // result side: random gap per result, plus one long hold-off
  initial begin
    int gap, taken, hold;
    gap = 0;
    taken = 0;
    hold = 0;
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        taken++;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (taken == 250) hold = 500;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
      @(posedge clk);
    end
  end

  // the caller drops cfg_we after the last write of a group
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send(rrt_pkg::in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pkt(logic [31:0] off, logic [7:0] cnt, logic inf);
    rrt_pkg::in_t it;
    it.kind = rrt_pkg::KIND_PACKET;
    it.offset = off;
    it.count = cnt;
    it.infer_length = inf;
    send(it);
  endtask

  task automatic adopt();
    rrt_pkg::in_t it;
    it.kind = rrt_pkg::KIND_ADOPT;
    it.offset = $urandom;
    it.count = 8'($urandom);
    it.infer_length = 1'($urandom);
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_RANGES * 2 + 8) @(posedge clk);
  endtask

  function automatic rrt_pkg::in_t random_request();
    rrt_pkg::in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.kind = rrt_pkg::KIND_PACKET;
    it.infer_length = ($urandom_range(0, 99) < 15);
    it.offset = $urandom_range(0, span);
    it.count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, PACKET_SIZE));
    if (pick < 10) begin
      it.kind = rrt_pkg::KIND_ADOPT;
      it.offset = $urandom;
      it.count = 8'($urandom);
      it.infer_length = 1'($urandom);
    end else if (pick < 13) begin
      // noise that must not leave a range behind
      it.offset = $urandom;
      it.count = ($urandom_range(0, 1) == 0) ? 8'd0
                                             : 8'($urandom_range(PACKET_SIZE + 1, 255));
    end else if (pick < 15) begin
      it.offset = 32'hFFFF_FFFF - $urandom_range(0, 120);
      it.count = 8'($urandom_range(0, 255));
      if (it.offset + it.count <= 32'hFFFF_FFFF && it.offset + it.count >= it.offset)
        it.count = 0;
    end
    return it;
  endfunction

  initial begin
    int ph, k;
    logic [31:0] slack_v, req_v;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 0;
    span = 2000;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_reg(rrt_pkg::REG_TRUSTED_VALID, 32'd1);
    write_reg(rrt_pkg::REG_TRUSTED_LEN, 32'd1000);
    write_reg(rrt_pkg::REG_SLACK, 32'd0);
    write_reg(rrt_pkg::REG_MAX_REQ, rrt_pkg::ALL_ONES);
    cfg_we <= 0;

    // directed: adopt with nothing pending, invalid extremes, fill the list, overflow it
    adopt();
    send_pkt(32'hFFFF_FFFF, 8'd0, 1'b1);
    send_pkt(32'hFFFF_FFF0, 8'd20, 1'b0);
    send_pkt(32'd0, 8'd255, 1'b0);
    send_pkt(32'd0, 8'(PACKET_SIZE + 1), 1'b0);
    send_pkt(32'd500, 8'd0, 1'b1);
    send_pkt(32'd3000, 8'd10, 1'b1);
    adopt();
    adopt();
    for (k = 0; k < 15; k++) send_pkt(32'(k * 200), 8'd10, 1'b0);
    send_pkt(32'd5000, 8'd10, 1'b0);
    send_pkt(32'd0, 8'(PACKET_SIZE), 1'b0);
    send_pkt(32'd90, 8'd20, 1'b1);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: slack_v = 32'd0;
        1: slack_v = rrt_pkg::ALL_ONES;
        2: slack_v = $urandom_range(1, 300);
        default: slack_v = $urandom;
      endcase
      case (ph % 4)
        0: req_v = rrt_pkg::ALL_ONES;
        1: req_v = 32'd0;
        2: req_v = $urandom_range(1, 400);
        default: req_v = 32'd1;
      endcase
      write_reg(rrt_pkg::REG_TRUSTED_VALID, $urandom);
      write_reg(rrt_pkg::REG_TRUSTED_LEN, $urandom);
      write_reg(rrt_pkg::REG_SLACK, slack_v);
      write_reg(rrt_pkg::REG_MAX_REQ, req_v);
      cfg_we <= 0;
      no_idle = (ph == 5);
      span = (ph < 3) ? 3400 : 3400 + ph * 600;
      for (k = 0; k < 100; k++) send(random_request());
      drain();
    end

    while (outstanding != 0) @(posedge clk);
    repeat (MAX_RANGES * 2 + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_received_range_tracker_unit: PASS");
    end else begin
      $display("tb_received_range_tracker_unit: FAIL");
    end
    $finish;
  end
endmodule
